>>> rtl/core/lrbc_pkg.sv
// Shared types, codes and constants for the link reconnect backoff controller.
package lrbc_pkg;

    localparam int DELAY_WIDTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int ADDR_WIDTH  = 48;
    localparam int CFG_WIDTH   = 48;
    localparam int IDX_WIDTH   = 3;

    localparam logic [DELAY_WIDTH-1:0] RST_INITIAL_DELAY = DELAY_WIDTH'(5000);
    localparam logic [DELAY_WIDTH-1:0] RST_MAX_DELAY     = DELAY_WIDTH'(60000);
    localparam logic [DELAY_WIDTH-1:0] RST_ATTEMPT_TMO   = DELAY_WIDTH'(20000);

    typedef logic [DELAY_WIDTH-1:0] t_delay;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [ADDR_WIDTH-1:0]  t_addr;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_PROFILE = 2'd1,
        KIND_LINK    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        LS_DISCONNECTED  = 3'd0,
        LS_CONNECTING    = 3'd1,
        LS_CONNECTED     = 3'd2,
        LS_SERVICE_UP    = 3'd3,
        LS_DISCONNECTING = 3'd4
    } t_link_state;

    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_CONNECT    = 2'd1,
        ACT_DISCONNECT = 2'd2,
        ACT_DROP       = 2'd3
    } t_action;

    typedef enum logic [IDX_WIDTH-1:0] {
        CFG_INITIAL_DELAY = 3'd0,
        CFG_MAX_DELAY     = 3'd1,
        CFG_ATTEMPT_TMO   = 3'd2,
        CFG_PEER_VALID    = 3'd3,
        CFG_PEER_ADDR     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] link_state;
        t_addr      remote_address;
        logic       peer_bonded;
        logic       connect_accepted;
    } t_item;

    typedef struct packed {
        t_delay initial_delay;
        t_delay max_delay;
        t_delay attempt_tmo;
    } t_cfg;

    typedef struct packed {
        logic   profile_seen;
        logic   peer_known;
        logic   link_connected;
        logic   in_flight;
        logic   cancel_pending;
        logic   armed;
        t_delay remaining;
        t_delay backoff;
        t_count attempts;
        t_addr  peer_addr;
    } t_state;

    typedef struct packed {
        t_action action;
        t_addr   target_address;
        t_delay  next_delay;
        t_count  attempt_total;
        logic    link_up;
    } t_result;

endpackage

>>> rtl/core/link_reconnect_backoff_controller_unit.sv
// Link reconnect backoff controller: input register, step logic, state and result register.
// An accepted beat passes the input register, then the result register, to the output.
// Throughput: one item per cycle while i_stall does not hold a valid output beat.
// Reset (synchronous, active low) restores delay defaults 5000/60000/20000 ms, clears the
// saved peer, flags, countdown and attempt count, and empties both pipeline registers.
module link_reconnect_backoff_controller_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lrbc_pkg::IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [lrbc_pkg::CFG_WIDTH-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_kind,
    input  logic [2:0]                       i_link_state,
    input  logic [lrbc_pkg::ADDR_WIDTH-1:0]  i_remote_address,
    input  logic                             i_peer_bonded,
    input  logic                             i_connect_accepted,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_action,
    output logic [lrbc_pkg::ADDR_WIDTH-1:0]  o_target_address,
    output logic [lrbc_pkg::DELAY_WIDTH-1:0] o_next_delay_ms,
    output logic [lrbc_pkg::COUNT_WIDTH-1:0] o_attempt_total,
    output logic                             o_link_up
);
    import lrbc_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    t_cfg    cfg;
    t_state  cur_state;
    t_state  next_state;
    t_result step_res;
    logic    r_out_valid;
    t_result r_out;

    assign in_item.kind             = i_kind;
    assign in_item.link_state       = i_link_state;
    assign in_item.remote_address   = i_remote_address;
    assign in_item.peer_bonded      = i_peer_bonded;
    assign in_item.connect_accepted = i_connect_accepted;

    assign advance = stage_valid && (!r_out_valid || !i_stall);

    lrbc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (in_item),
        .i_advance    (advance),
        .o_stall      (o_stall),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    lrbc_step u_step (
        .i_item   (stage_item),
        .i_cfg    (cfg),
        .i_state  (cur_state),
        .o_state  (next_state),
        .o_result (step_res)
    );

    lrbc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_load     (advance),
        .i_state    (next_state),
        .o_cfg      (cfg),
        .o_state    (cur_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_action         = r_out.action;
    assign o_target_address = r_out.target_address;
    assign o_next_delay_ms  = r_out.next_delay;
    assign o_attempt_total  = r_out.attempt_total;
    assign o_link_up        = r_out.link_up;

    a_none_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_NONE |-> o_target_address == '0)
        else $error("target address set without an action");

    a_link_up_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_link_up |-> o_action == ACT_NONE)
        else $error("action issued while the link is up");

    a_connect_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_CONNECT |-> o_attempt_total != '0)
        else $error("connect issued with zero attempt count");

    a_attempts_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> cur_state.attempts >= $past(cur_state.attempts))
        else $error("attempt count decreased");

endmodule

>>> rtl/core/lrbc_in_stage.sv
// Input register that captures one item beat and holds it until the step fires.
module lrbc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lrbc_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_stall,
    output logic          o_item_valid,
    output lrbc_pkg::t_item o_item
);
    import lrbc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  take;

    assign o_stall      = r_valid && !i_advance;
    assign take         = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/core/lrbc_step.sv
// Next-state and result logic for one item, including the deadline due check.
module lrbc_step (
    input  lrbc_pkg::t_item   i_item,
    input  lrbc_pkg::t_cfg    i_cfg,
    input  lrbc_pkg::t_state  i_state,
    output lrbc_pkg::t_state  o_state,
    output lrbc_pkg::t_result o_result
);
    import lrbc_pkg::*;

    function automatic t_state plan_retry(t_state s, t_delay max_delay);
        logic [DELAY_WIDTH:0] twice;
        t_state               r;
        r           = s;
        twice       = {s.backoff, 1'b0};
        r.remaining = s.backoff;
        r.armed     = 1'b1;
        if (s.backoff < max_delay) begin
            r.backoff = (twice > {1'b0, max_delay}) ? max_delay : twice[DELAY_WIDTH-1:0];
        end
        return r;
    endfunction

    t_state  n;
    t_action act;
    logic    due;

    always_comb begin
        n   = i_state;
        act = ACT_NONE;
        due = 1'b0;
        unique case (i_item.kind)
            KIND_TICK: begin
                if (n.armed && n.remaining != '0) begin
                    n.remaining = n.remaining - t_delay'(1);
                end
            end
            KIND_PROFILE: begin
                n.profile_seen = 1'b1;
                if (n.peer_known && !n.link_connected && !n.in_flight) begin
                    n.remaining = i_cfg.initial_delay;
                    n.armed     = 1'b1;
                end
            end
            KIND_LINK: begin
                unique case (i_item.link_state)
                    LS_CONNECTING, LS_CONNECTED: begin
                        n.in_flight = 1'b1;
                        n.remaining = i_cfg.attempt_tmo;
                        n.armed     = 1'b1;
                    end
                    LS_SERVICE_UP: begin
                        n.peer_addr      = i_item.remote_address;
                        n.peer_known     = 1'b1;
                        n.link_connected = 1'b1;
                        n.in_flight      = 1'b0;
                        n.cancel_pending = 1'b0;
                        n.armed          = 1'b0;
                        n.remaining      = '0;
                        n.backoff        = i_cfg.initial_delay;
                    end
                    LS_DISCONNECTED: begin
                        n.link_connected = 1'b0;
                        n.in_flight      = 1'b0;
                        if (n.cancel_pending) begin
                            n.cancel_pending = 1'b0;
                        end else if (n.profile_seen && n.peer_known) begin
                            n = plan_retry(n, i_cfg.max_delay);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        due = n.profile_seen && n.peer_known && !n.link_connected
              && n.armed && (n.remaining == '0);
        if (due) begin
            priority if (n.in_flight) begin
                n.cancel_pending = 1'b1;
                n.in_flight      = 1'b0;
                act              = ACT_DISCONNECT;
                n                = plan_retry(n, i_cfg.max_delay);
            end else if (!i_item.peer_bonded) begin
                n.peer_known = 1'b0;
                n.armed      = 1'b0;
                act          = ACT_DROP;
            end else begin
                if (n.attempts != '1) begin
                    n.attempts = n.attempts + t_count'(1);
                end
                act = ACT_CONNECT;
                if (i_item.connect_accepted) begin
                    n.in_flight = 1'b1;
                    n.remaining = i_cfg.attempt_tmo;
                    n.armed     = 1'b1;
                end else begin
                    n = plan_retry(n, i_cfg.max_delay);
                end
            end
        end
    end

    assign o_state                  = n;
    assign o_result.action          = act;
    assign o_result.target_address  = (act != ACT_NONE) ? n.peer_addr : '0;
    assign o_result.next_delay      = n.backoff;
    assign o_result.attempt_total   = n.attempts;
    assign o_result.link_up         = n.link_connected;

endmodule

>>> rtl/core/lrbc_regs.sv
// Configuration registers and controller state registers.
module lrbc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lrbc_pkg::IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [lrbc_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                         i_load,
    input  lrbc_pkg::t_state             i_state,
    output lrbc_pkg::t_cfg               o_cfg,
    output lrbc_pkg::t_state             o_state
);
    import lrbc_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_delay <= RST_INITIAL_DELAY;
            r_cfg.max_delay     <= RST_MAX_DELAY;
            r_cfg.attempt_tmo   <= RST_ATTEMPT_TMO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INITIAL_DELAY: r_cfg.initial_delay <= i_cfg_data[DELAY_WIDTH-1:0];
                CFG_MAX_DELAY:     r_cfg.max_delay     <= i_cfg_data[DELAY_WIDTH-1:0];
                CFG_ATTEMPT_TMO:   r_cfg.attempt_tmo   <= i_cfg_data[DELAY_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.profile_seen   <= 1'b0;
            r_state.peer_known     <= 1'b0;
            r_state.link_connected <= 1'b0;
            r_state.in_flight      <= 1'b0;
            r_state.cancel_pending <= 1'b0;
            r_state.armed          <= 1'b0;
            r_state.remaining      <= '0;
            r_state.backoff        <= RST_INITIAL_DELAY;
            r_state.attempts       <= '0;
            r_state.peer_addr      <= '0;
        end else if (i_load) begin
            r_state <= i_state;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INITIAL_DELAY: r_state.backoff    <= i_cfg_data[DELAY_WIDTH-1:0];
                CFG_PEER_VALID:    r_state.peer_known <= i_cfg_data[0];
                CFG_PEER_ADDR:     r_state.peer_addr  <= i_cfg_data[ADDR_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg   = r_cfg;
    assign o_state = r_state;

endmodule
